// File: rtl/ascii_hex_telemetry_parser_assert.svh
// ----------------------------------------------------------------------------
// ascii_hex_telemetry_parser assertion macros
// Clocked on clk, held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASCII_HEX_TELEMETRY_PARSER_ASSERT_SVH
`define ASCII_HEX_TELEMETRY_PARSER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define AHTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define AHTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ahtp_pkg.sv
// ----------------------------------------------------------------------------
// ahtp_pkg
// Character codes, packet and kind codes, and helpers for the telemetry parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ahtp_pkg;

  localparam logic [7:0] CHAR_DOLLAR  = 8'd36;
  localparam logic [7:0] CHAR_A       = 8'd65;
  localparam logic [7:0] DIGIT_LIMIT  = 8'd57;
  localparam logic [7:0] DIGIT_OFFSET = 8'd48;
  localparam logic [7:0] ALPHA_OFFSET = 8'd55;

  localparam logic [7:0] PKT_SATS = 8'd0;
  localparam logic [7:0] PKT_LON  = 8'd2;
  localparam logic [7:0] PKT_LAT  = 8'd3;
  localparam logic [7:0] PKT_ALT  = 8'd10;

  localparam logic [1:0] KIND_SATS = 2'd0;
  localparam logic [1:0] KIND_ALT  = 2'd1;
  localparam logic [1:0] KIND_LON  = 2'd2;
  localparam logic [1:0] KIND_LAT  = 2'd3;

  // ceil(2^11 / 3): exact floor(x / 3) for x below 768
  localparam logic [9:0]  RECIP3     = 10'd683;
  // floor(2^32 / 3); 2^32 leaves remainder one
  localparam logic [31:0] THIRD_2_32 = 32'd1431655765;

  localparam logic [33:0] POS_LIMIT = 34'h0_7FFF_FFFF;
  localparam logic [33:0] NEG_LIMIT = 34'h0_8000_0000;

  typedef struct packed {
    logic [7:0] quot;
    logic [1:0] rem;
  } div3_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    digit_value = (c <= DIGIT_LIMIT) ? (c - DIGIT_OFFSET) : (c - ALPHA_OFFSET);
  endfunction

  // one base-256 digit of long division by three
  function automatic div3_t div3_step(input logic [1:0] rem_in, input logic [7:0] b);
    logic [9:0]  x;
    logic [19:0] prod;
    logic [9:0]  back;
    div3_t       res;
    x        = {rem_in, b};
    prod     = {10'd0, x} * {10'd0, RECIP3};
    res.quot = prod[18:11];
    back     = x - ({2'd0, res.quot} + {1'b0, res.quot, 1'b0});
    res.rem  = back[1:0];
    div3_step = res;
  endfunction

  // floor((5r + 1) / 3) for r in 0..2
  function automatic logic [1:0] round_add(input logic [1:0] r);
    logic [1:0] k;
    unique case (r)
      2'd0:    k = 2'd0;
      2'd1:    k = 2'd2;
      default: k = 2'd3;
    endcase
    round_add = k;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ascii_hex_telemetry_parser.sv
// ----------------------------------------------------------------------------
// ascii_hex_telemetry_parser
// Byte-serial decoder of '$'-framed hex telemetry packets.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle unless in_stall is high; every byte gives
// exactly one result item, in order, through stage 1, stage 2 and the outputs.
// The frame word is divided by three one byte at a time as hex pairs arrive,
// so the five-thirds scaling needs only a short add and a saturating negate
// in the two stages behind the parser. in_stall rises only while a result is
// held by out_stall with the pipeline full.
`default_nettype none

module ascii_hex_telemetry_parser (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [7:0]        rx_byte,
  output logic              out_valid,
  input  wire               out_stall,
  output logic              frame_valid,
  output logic [1:0]        item_kind,
  output logic signed [31:0] item_value
);

  `include "ascii_hex_telemetry_parser_assert.svh"

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_LETTER = 2'd1;
  localparam logic [1:0] PH_HEX    = 2'd2;

  // parser state
  logic [1:0]  phase, phase_next;
  logic [2:0]  char_count, char_count_next;
  logic [7:0]  packet_number, packet_number_next;
  logic [3:0]  hi_nib, hi_nib_next;
  logic [15:0] top16, top16_next;
  logic [23:0] quot, quot_next;
  logic [1:0]  rem, rem_next;

  // stage 1
  logic        s1_valid;
  logic        s1_fv, s1_fv_next;
  logic [1:0]  s1_kind, s1_kind_next;
  logic        s1_scaled, s1_scaled_next;
  logic        s1_neg, s1_neg_next;
  logic [31:0] s1_quot, s1_quot_next;
  logic [1:0]  s1_rem, s1_rem_next;
  logic [31:0] s1_plain, s1_plain_next;

  // stage 2
  logic        s2_valid;
  logic        s2_fv;
  logic [1:0]  s2_kind;
  logic        s2_scaled;
  logic        s2_neg;
  logic [33:0] s2_mag, s2_mag_next;
  logic [31:0] s2_plain;

  logic [31:0] value_next;

  logic out_en, s2_en, s1_en, accept;
  logic [7:0] dv;
  logic [7:0] pair;
  ahtp_pkg::div3_t step;
  logic [31:0] a_adj;
  logic [1:0]  r_adj;

  assign out_en   = !out_valid || !out_stall;
  assign s2_en    = !s2_valid || out_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;
  assign accept   = in_valid && s1_en;

  assign dv   = ahtp_pkg::digit_value(rx_byte);
  assign pair = {hi_nib, 4'd0} + dv;
  assign step = ahtp_pkg::div3_step((char_count == 3'd1) ? 2'd0 : rem, pair);

  always_comb begin
    phase_next         = phase;
    char_count_next    = char_count;
    packet_number_next = packet_number;
    hi_nib_next        = hi_nib;
    top16_next         = top16;
    quot_next          = quot;
    rem_next           = rem;
    s1_fv_next         = 1'b0;
    s1_kind_next       = ahtp_pkg::KIND_SATS;
    s1_scaled_next     = 1'b0;
    s1_neg_next        = 1'b0;
    s1_quot_next       = {quot, step.quot};
    s1_rem_next        = step.rem;
    s1_plain_next      = 32'd0;
    unique case (phase)
      PH_IDLE: begin
        if (rx_byte == ahtp_pkg::CHAR_DOLLAR) begin
          char_count_next = 3'd0;
          phase_next      = PH_LETTER;
        end
      end
      PH_LETTER: begin
        packet_number_next = rx_byte - ahtp_pkg::CHAR_A;
        phase_next         = PH_HEX;
      end
      PH_HEX: begin
        if (!char_count[0]) begin
          hi_nib_next = dv[3:0];
        end else begin
          quot_next = {quot[15:0], step.quot};
          rem_next  = step.rem;
        end
        if (char_count == 3'd1) top16_next[15:8] = pair;
        if (char_count == 3'd3) top16_next[7:0]  = pair;
        if (char_count == 3'd7) begin
          char_count_next = 3'd0;
          phase_next      = PH_IDLE;
          s1_neg_next     = top16[15];
          unique case (packet_number)
            ahtp_pkg::PKT_SATS: begin
              s1_fv_next    = 1'b1;
              s1_kind_next  = ahtp_pkg::KIND_SATS;
              s1_plain_next = {24'd0, top16[15:8]};
            end
            ahtp_pkg::PKT_ALT: begin
              s1_fv_next    = 1'b1;
              s1_kind_next  = ahtp_pkg::KIND_ALT;
              s1_plain_next = {{16{top16[15]}}, top16};
            end
            ahtp_pkg::PKT_LON: begin
              s1_fv_next     = 1'b1;
              s1_kind_next   = ahtp_pkg::KIND_LON;
              s1_scaled_next = 1'b1;
            end
            ahtp_pkg::PKT_LAT: begin
              s1_fv_next     = 1'b1;
              s1_kind_next   = ahtp_pkg::KIND_LAT;
              s1_scaled_next = 1'b1;
            end
            default: begin
              s1_fv_next = 1'b0;
            end
          endcase
        end else begin
          char_count_next = char_count + 3'd1;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        char_count_next = 3'd0;
      end
    endcase
  end

  // negative word: |w| = 2^32 - w, refolded into quotient and remainder by three
  always_comb begin
    a_adj = s1_quot;
    r_adj = s1_rem;
    if (s1_neg) begin
      unique case (s1_rem)
        2'd0: begin
          a_adj = ahtp_pkg::THIRD_2_32 - s1_quot;
          r_adj = 2'd1;
        end
        2'd1: begin
          a_adj = ahtp_pkg::THIRD_2_32 - s1_quot;
          r_adj = 2'd0;
        end
        default: begin
          a_adj = ahtp_pkg::THIRD_2_32 - s1_quot - 32'd1;
          r_adj = 2'd2;
        end
      endcase
    end
    s2_mag_next = {a_adj, 2'b00} + {2'b00, a_adj}
                + {32'd0, ahtp_pkg::round_add(r_adj)};
  end

  always_comb begin
    value_next = s2_plain;
    if (s2_scaled) begin
      if (!s2_neg) begin
        value_next = (s2_mag > ahtp_pkg::POS_LIMIT) ? ahtp_pkg::POS_LIMIT[31:0] : s2_mag[31:0];
      end else begin
        value_next = (s2_mag > ahtp_pkg::NEG_LIMIT) ? ahtp_pkg::NEG_LIMIT[31:0]
                                                     : (~s2_mag[31:0] + 32'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      char_count <= 3'd0;
    end else if (accept) begin
      phase      <= phase_next;
      char_count <= char_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      packet_number <= packet_number_next;
      hi_nib        <= hi_nib_next;
      top16         <= top16_next;
      quot          <= quot_next;
      rem           <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en)  s1_valid  <= accept;
      if (s2_en)  s2_valid  <= s1_valid;
      if (out_en) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fv     <= s1_fv_next;
      s1_kind   <= s1_kind_next;
      s1_scaled <= s1_scaled_next;
      s1_neg    <= s1_neg_next;
      s1_quot   <= s1_quot_next;
      s1_rem    <= s1_rem_next;
      s1_plain  <= s1_plain_next;
    end
    if (s2_en && s1_valid) begin
      s2_fv     <= s1_fv;
      s2_kind   <= s1_kind;
      s2_scaled <= s1_scaled;
      s2_neg    <= s1_neg;
      s2_mag    <= s2_mag_next;
      s2_plain  <= s1_plain;
    end
    if (out_en && s2_valid) begin
      frame_valid <= s2_fv;
      item_kind   <= s2_kind;
      item_value  <= $signed(value_next);
    end
  end

  `AHTP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "stall without held result")
  `AHTP_ASSERT_NEXT(a_frame_end, accept && phase == PH_HEX && char_count == 3'd7,
                    phase == PH_IDLE && char_count == 3'd0, "frame did not close")
  `AHTP_ASSERT_NOW(a_sats_range, out_valid && frame_valid && item_kind == ahtp_pkg::KIND_SATS,
                   item_value[31:8] == 24'd0, "satellite count out of range")

endmodule

`default_nettype wire
